>>> sv/ttw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer package
// Shared constants, command codes and state encoding for the text terminal
// writer and its testbench.
// ----------------------------------------------------------------------------
package ttw_pkg;

  // Default screen geometry
  localparam int unsigned DefaultCols = 80;
  localparam int unsigned DefaultRows = 25;

  // Fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned ColourW = 4;
  localparam int unsigned RowW    = 5;
  localparam int unsigned ColW    = 7;
  localparam int unsigned CellW   = 16;

  // Command codes
  localparam logic [CmdW-1:0] CMD_WRITE     = 3'd0;
  localparam logic [CmdW-1:0] CMD_WRITE_DEF = 3'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR     = 3'd2;
  localparam logic [CmdW-1:0] CMD_SET_BG    = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ      = 3'd4;

  // Special characters and attributes
  localparam logic [CharW-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CharW-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CharW-1:0] CH_SPACE     = 8'h20;
  localparam logic [CharW-1:0] ATTR_WHITE   = 8'h0F;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_FILL   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

endpackage

>>> sv/ttw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/text_terminal_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer
// Text cell store with cursor: coloured writes, backspace, clear, scrolling,
// per-cell background set and cell read.
// ----------------------------------------------------------------------------
// The screen (ROWS x COLS words of {attribute, glyph}) lives in one
// simple dual-port RAM, and one command word is handled at a time. After
// reset the block runs a clearing pass over all ROWS*COLS cells (2000 by
// default) with in_stall_o high. A character write, backspace, unused
// command or out-of-range set/read goes straight to the result; an in-range
// set background or read first reads the cell, then set background writes
// it back modified. A write that overflows the last row scrolls: the copy
// moves one cell per cycle through the RAM port, then the last row is
// blanked. Clear blanks every cell. The result word sits in an output
// register, so the next command word is accepted while a result still waits.
module text_terminal_writer #(
  parameter int unsigned COLS = ttw_pkg::DefaultCols,
  parameter int unsigned ROWS = ttw_pkg::DefaultRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ttw_pkg::CmdW-1:0]      cmd_i,
  input  logic [ttw_pkg::CharW-1:0]     char_code_i,
  input  logic [ttw_pkg::ColourW-1:0]   text_color_i,
  input  logic [ttw_pkg::ColourW-1:0]   back_color_i,
  input  logic [ttw_pkg::RowW-1:0]      row_i,
  input  logic [ttw_pkg::ColW-1:0]      col_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ttw_pkg::CellW-1:0]     cell_word_o,
  output logic [ttw_pkg::ColW-1:0]      current_column_o,
  output logic [ttw_pkg::RowW-1:0]      current_row_o,
  output logic                          scrolled_o
);

  import ttw_pkg::*;

  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned PW    = $clog2(Cells + 1);

  localparam logic [AW-1:0]    ColsA    = AW'(COLS);
  localparam logic [PW-1:0]    ColsP    = PW'(COLS);
  localparam logic [PW-1:0]    CellsP   = PW'(Cells);
  localparam logic [PW-1:0]    LastP    = PW'(Cells - 1);
  localparam logic [ColW-1:0]  LastCol  = ColW'(COLS - 1);
  localparam logic [RowW-1:0]  LastRow  = RowW'(ROWS - 1);

  // Control state
  state_e             state_q, state_d;
  logic               init_q, init_d;
  logic               pend_q, pend_d;
  logic [PW-1:0]      ptr_q, ptr_d;
  logic [PW-1:0]      wptr_q, wptr_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [CellW-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;

  // Per-command payload
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [ColourW-1:0] bg_q, bg_d;
  logic [CellW-1:0]   word_q, word_d;
  logic               scr_q, scr_d;

  // Result register
  logic [CellW-1:0]   out_word_q;
  logic [ColW-1:0]    out_col_q;
  logic [RowW-1:0]    out_row_q;
  logic               out_scr_q;
  logic               out_load;

  // RAM port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CellW-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [CellW-1:0]   mem_rdata;

  // Address helpers
  logic [AW-1:0]      cur_addr;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               in_acc;
  logic               is_bs;
  logic               is_nl;
  logic               wrap;
  logic [CharW-1:0]   attr;

  assign cur_addr = AW'(row_q) * ColsA + AW'(col_q);
  assign in_addr  = AW'(row_i) * ColsA + AW'(col_i);
  assign in_range = ({1'b0, row_i} < (RowW+1)'(ROWS)) && ({1'b0, col_i} < (ColW+1)'(COLS));
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_bs    = (cmd_i == CMD_WRITE_DEF) && (char_code_i == CH_BACKSPACE);
  assign is_nl    = (char_code_i == CH_NEWLINE);
  assign wrap     = is_nl || (col_q == LastCol);
  assign attr     = (cmd_i == CMD_WRITE) ? {4'b0, text_color_i} : ATTR_WHITE;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    pend_d    = pend_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    col_d     = col_q;
    row_d     = row_q;
    fill_d    = fill_q;
    cmd_d     = cmd_q;
    bg_d      = bg_q;
    word_d    = word_q;
    scr_d     = scr_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wptr_q[AW-1:0];
    mem_wdata = fill_q;
    mem_raddr = (state_q == ST_SCROLL) ? ptr_q[AW-1:0] : in_addr;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = cmd_i;
          bg_d   = back_color_i;
          word_d = '0;
          scr_d  = 1'b0;
          state_d = ST_DONE;
          case (cmd_i)
            CMD_WRITE, CMD_WRITE_DEF: begin
              if (is_bs) begin
                // step back one cell (not past the home cell) and blank it
                mem_we    = 1'b1;
                mem_wdata = {8'h00, CH_SPACE};
                if (col_q != '0) begin
                  col_d     = col_q - 1'b1;
                  mem_waddr = cur_addr - 1'b1;
                end else if (row_q != '0) begin
                  col_d     = LastCol;
                  row_d     = row_q - 1'b1;
                  mem_waddr = cur_addr - 1'b1;
                end else begin
                  mem_waddr = '0;
                end
              end else begin
                if (!is_nl) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = {attr, char_code_i};
                end
                if (wrap) begin
                  col_d = '0;
                  if (row_q == LastRow) begin
                    // overflow: shift everything up one row
                    scr_d   = 1'b1;
                    ptr_d   = ColsP;
                    wptr_d  = '0;
                    pend_d  = 1'b0;
                    fill_d  = {8'h00, CH_SPACE};
                    state_d = ST_SCROLL;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              fill_d  = {back_color_i, 4'b0, CH_SPACE};
              wptr_d  = '0;
              col_d   = '0;
              row_d   = '0;
              state_d = ST_FILL;
            end
            CMD_SET_BG, CMD_READ: begin
              if (in_range) begin
                wptr_d  = PW'(in_addr);
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        // read data is back: modify and write, or return it
        if (cmd_q == CMD_SET_BG) begin
          mem_we    = 1'b1;
          mem_wdata = {bg_q, 4'b0, mem_rdata[7:0]};
        end else begin
          word_d = mem_rdata;
        end
        state_d = ST_DONE;
      end

      ST_SCROLL: begin
        // read one row ahead, write the previous read back one row up
        if (ptr_q != CellsP) begin
          ptr_d  = ptr_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          wptr_d    = wptr_q + 1'b1;
        end
        if (ptr_q == CellsP && !pend_q) begin
          state_d = ST_FILL;
        end
      end

      ST_FILL: begin
        // one cell a cycle from wptr to the end of the store
        mem_we = 1'b1;
        wptr_d = wptr_q + 1'b1;
        if (wptr_q == LastP) begin
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Result handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      init_q      <= 1'b1;
      pend_q      <= 1'b0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      pend_q      <= pend_d;
      ptr_q       <= ptr_d;
      wptr_q      <= wptr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    bg_q   <= bg_d;
    word_q <= word_d;
    scr_q  <= scr_d;
    if (out_load) begin
      out_word_q <= word_q;
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_scr_q  <= scr_q;
    end
  end

  // Cell store
  ttw_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign cell_word_o      = out_word_q;
  assign current_column_o = out_col_q;
  assign current_row_o    = out_row_q;
  assign scrolled_o       = out_scr_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives command words into the text terminal writer and checks every result
// word against a cell-store predictor kept in a small scoreboard class.
// Coverage: a short directed part, then random text runs, newline bursts,
// cell pokes, reads, clears and unused commands. The run has three idling
// phases, a long result hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_top;

  import ttw_pkg::*;

  localparam int unsigned Cols     = ttw_pkg::DefaultCols;
  localparam int unsigned Rows     = ttw_pkg::DefaultRows;
  localparam int unsigned NumCells = Rows * Cols;

  // Command codes the block leaves unused
  localparam logic [CmdW-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CmdW-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CmdW-1:0] CMD_UNUSED_HI  = 3'd7;

  // Longest single command is a scroll, about one pass over the store
  localparam int unsigned DrainCycles = NumCells + 100;
  localparam int unsigned MaxReports  = 10;
  // At most about 550 commands, each at worst one pass over the store plus
  // stalls, about 4.5 ms; allow well over 6x
  localparam int unsigned TimeoutNs   = 30_000_000;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [CharW-1:0]   glyph;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
  } term_cmd_t;

  typedef struct packed {
    logic [CellW-1:0] cell_word;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             scrolled;
  } term_report_t;

  // Cell store predictor and result checker
  class terminal_scoreboard;
    logic [CellW-1:0] screen [NumCells];
    int unsigned      cur_col;
    int unsigned      cur_row;
    term_report_t     awaited [$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      scrolls_seen;
    int unsigned      cmd_seen [8];

    function new();
      foreach (screen[i]) screen[i] = '0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      cur_col      = 0;
      cur_row      = 0;
      mismatches   = 0;
      results_seen = 0;
      scrolls_seen = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Shift rows up by one, blank the last row and park the cursor there
    function void scroll_up_one();
      for (int i = 0; i < (Rows - 1) * Cols; i++) screen[i] = screen[i + Cols];
      for (int i = (Rows - 1) * Cols; i < NumCells; i++) screen[i] = {8'h00, CH_SPACE};
      cur_col = 0;
      cur_row = Rows - 1;
    endfunction

    function bit advance_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= Rows) begin
        scroll_up_one();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit put_glyph(input logic [CharW-1:0] ch, input logic [7:0] attr);
      if (ch == CH_NEWLINE) return advance_row();
      screen[cur_row * Cols + cur_col] = {attr, ch};
      cur_col++;
      if (cur_col >= Cols) return advance_row();
      return 1'b0;
    endfunction

    // Backspace; at the home cell the cursor stays put
    function void step_back();
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_col = Cols - 1;
        cur_row--;
      end
      screen[cur_row * Cols + cur_col] = {8'h00, CH_SPACE};
    endfunction

    // Accepted command word: update the store and queue the expected result
    function void note_command(input term_cmd_t c);
      term_report_t rep;
      int unsigned  k;
      rep = '0;
      cmd_seen[c.cmd]++;
      case (c.cmd)
        CMD_WRITE: begin
          rep.scrolled = put_glyph(c.glyph, {4'h0, c.fg});
        end
        CMD_WRITE_DEF: begin
          if (c.glyph == CH_BACKSPACE) step_back();
          else rep.scrolled = put_glyph(c.glyph, ATTR_WHITE);
        end
        CMD_CLEAR: begin
          foreach (screen[i]) screen[i] = {c.bg, 4'h0, CH_SPACE};
          cur_col = 0;
          cur_row = 0;
        end
        CMD_SET_BG: begin
          if (c.row < Rows && c.col < Cols) begin
            k = c.row * Cols + c.col;
            screen[k] = {c.bg, 4'h0, screen[k][7:0]};
          end
        end
        CMD_READ: begin
          if (c.row < Rows && c.col < Cols) rep.cell_word = screen[c.row * Cols + c.col];
        end
        default: ;
      endcase
      rep.column = cur_col[ColW-1:0];
      rep.row    = cur_row[RowW-1:0];
      awaited.push_back(rep);
    endfunction

    // Accepted result word: compare with the oldest expectation
    function void check_result(input term_report_t got);
      term_report_t want;
      results_seen++;
      if (got.scrolled) scrolls_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("tb: unexpected result word %h col %0d row %0d scrolled %0b",
                   got.cell_word, got.column, got.row, got.scrolled);
        return;
      end
      want = awaited.pop_front();
      if (got.cell_word !== want.cell_word || got.column !== want.column ||
          got.row !== want.row || got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("tb: mismatch on result %0d: expected word %h col %0d row %0d scr %0b,",
                   results_seen, want.cell_word, want.column, want.row, want.scrolled,
                   " got word %h col %0d row %0d scr %0b",
                   got.cell_word, got.column, got.row, got.scrolled);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i;
  logic [CharW-1:0]    char_code_i;
  logic [ColourW-1:0]  text_color_i;
  logic [ColourW-1:0]  back_color_i;
  logic [RowW-1:0]     row_i;
  logic [ColW-1:0]     col_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CellW-1:0]    cell_word_o;
  logic [ColW-1:0]     current_column_o;
  logic [RowW-1:0]     current_row_o;
  logic                scrolled_o;

  terminal_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        hold_request;
  int unsigned        items_sent;

  text_terminal_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .char_code_i      (char_code_i),
    .text_color_i     (text_color_i),
    .back_color_i     (back_color_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_word_o      (cell_word_o),
    .current_column_o (current_column_o),
    .current_row_o    (current_row_o),
    .scrolled_o       (scrolled_o)
  );

  // Clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on run length
  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

  function automatic term_cmd_t make_cmd(input logic [CmdW-1:0] op,
                                         input logic [CharW-1:0] glyph,
                                         input logic [ColourW-1:0] fg,
                                         input logic [ColourW-1:0] bg,
                                         input logic [RowW-1:0] row,
                                         input logic [ColW-1:0] col);
    term_cmd_t c;
    c.cmd   = op;
    c.glyph = glyph;
    c.fg    = fg;
    c.bg    = bg;
    c.row   = row;
    c.col   = col;
    return c;
  endfunction

  function automatic term_cmd_t random_fields(input logic [CmdW-1:0] op);
    return make_cmd(op, 8'($urandom), 4'($urandom), 4'($urandom),
                    5'($urandom), 7'($urandom));
  endfunction

  function automatic logic [CharW-1:0] printable_glyph();
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  // Offer one command word, with random idle cycles ahead of it
  task automatic send_command(input term_cmd_t c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c.cmd;
    char_code_i  <= c.glyph;
    text_color_i <= c.fg;
    back_color_i <= c.bg;
    row_i        <= c.row;
    col_i        <= c.col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(c);
    if (c.cmd <= CMD_READ) items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random traffic, mostly well-formed text with newlines and scrolling
  task automatic random_batch(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    int unsigned roll;
    term_cmd_t   c;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // text run, now and then long enough to wrap
        len = ($urandom_range(7) == 0) ? $urandom_range(95, 70) : $urandom_range(12, 1);
        repeat (len) begin
          c    = random_fields($urandom_range(1) ? CMD_WRITE : CMD_WRITE_DEF);
          roll = $urandom_range(99);
          if (roll < 8) begin
            c.cmd   = CMD_WRITE_DEF;
            c.glyph = CH_BACKSPACE;
          end else if (roll >= 14) begin
            c.glyph = printable_glyph();
          end
          send_command(c);
        end
        if ($urandom_range(99) < 60) begin
          c       = random_fields($urandom_range(1) ? CMD_WRITE : CMD_WRITE_DEF);
          c.glyph = CH_NEWLINE;
          send_command(c);
        end
      end else if (pick < 70) begin
        // newline burst, drives the cursor towards the bottom row
        repeat ($urandom_range(8, 1)) begin
          c       = random_fields($urandom_range(1) ? CMD_WRITE : CMD_WRITE_DEF);
          c.glyph = CH_NEWLINE;
          send_command(c);
        end
      end else if (pick < 85) begin
        // background poke followed by a read of the same cell
        c = random_fields(CMD_SET_BG);
        if ($urandom_range(99) < 80) begin
          c.row = 5'($urandom_range(Rows - 1));
          c.col = 7'($urandom_range(Cols - 1));
        end else if ($urandom_range(1)) begin
          c.row = 5'($urandom_range(31, Rows));
        end else begin
          c.col = 7'($urandom_range(127, Cols));
        end
        send_command(c);
        c.cmd = CMD_READ;
        send_command(c);
      end else if (pick < 92) begin
        send_command(random_fields(CMD_READ));
      end else if (pick < 96) begin
        send_command(random_fields(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO))));
      end else begin
        send_command(random_fields(CMD_CLEAR));
      end
    end
  endtask

  // Result side: checks accepted words and drives the stall
  initial begin : result_side
    int unsigned  hold_left;
    term_report_t got;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {cell_word_o, current_column_o, current_row_o, scrolled_o};
        sb.check_result(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Main stimulus
  initial begin
    sb            = new();
    send_idle_pct = 31;
    recv_idle_pct = 70;
    hold_request  = 0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    in_valid_i   <= 1'b0;
    cmd_i        <= CMD_READ;
    char_code_i  <= '0;
    text_color_i <= '0;
    back_color_i <= '0;
    row_i        <= '0;
    col_i        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, backspace across a row, range checks
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE,     8'hFF,        4'hF, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE,     8'h00,        4'h0, 4'hF, 5'd31, 7'd127));
    send_command(make_cmd(CMD_WRITE,     CH_NEWLINE,   4'h7, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE_DEF, 8'h5A,        4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE_DEF, CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE_DEF, CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_WRITE_DEF, CH_NEWLINE,   4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd1));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd79));
    send_command(make_cmd(CMD_SET_BG,    8'h00,        4'h0, 4'hF, 5'd0,  7'd0));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_SET_BG,    8'h00,        4'h0, 4'h5, 5'd24, 7'd79));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd24, 7'd79));
    send_command(make_cmd(CMD_SET_BG,    8'h00,        4'h0, 4'h3, 5'd25, 7'd0));
    send_command(make_cmd(CMD_SET_BG,    8'h00,        4'h0, 4'hF, 5'd31, 7'd127));
    send_command(make_cmd(CMD_SET_BG,    8'h00,        4'h0, 4'h9, 5'd0,  7'd80));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd31, 7'd127));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd80));
    send_command(make_cmd(CMD_UNUSED_LO,  8'h41, 4'h2, 4'h3, 5'd1, 7'd1));
    send_command(make_cmd(CMD_UNUSED_MID, 8'h0A, 4'hF, 4'hF, 5'd2, 7'd2));
    send_command(make_cmd(CMD_UNUSED_HI,  8'h08, 4'h0, 4'h0, 5'd0, 7'd0));
    send_command(make_cmd(CMD_CLEAR,     8'h00,        4'h0, 4'hF, 5'd0,  7'd0));
    // backspace at the home cell blanks it and keeps the cursor put
    send_command(make_cmd(CMD_WRITE_DEF, CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_READ,      8'h00,        4'h0, 4'h0, 5'd0,  7'd0));
    send_command(make_cmd(CMD_CLEAR,     8'h00,        4'h0, 4'h0, 5'd0,  7'd0));
    wait_all_results();

    // Random, busy sender and slow receiver
    random_batch(95);
    wait_all_results();

    // Random, slow sender and busy receiver
    send_idle_pct = 70;
    recv_idle_pct = 31;
    random_batch(95);
    wait_all_results();

    // No idling; first hold results back so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 64;
    repeat (10) begin
      send_command(make_cmd(CMD_WRITE, printable_glyph(), 4'($urandom), 4'($urandom),
                            5'($urandom), 7'($urandom)));
    end
    random_batch(85);
    wait_all_results();

    // Allow any stray result word time to show up
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d command words checked: %0d writes, %0d default writes, %0d clears,",
             sb.results_seen, sb.cmd_seen[CMD_WRITE], sb.cmd_seen[CMD_WRITE_DEF],
             sb.cmd_seen[CMD_CLEAR]);
    $display("tb: %0d background sets, %0d reads, %0d scrolls, %0d mismatches",
             sb.cmd_seen[CMD_SET_BG], sb.cmd_seen[CMD_READ], sb.scrolls_seen,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
